/* rtl/pma_pkg.sv */
// ----------------------------------------------------------------------------
// pma_pkg: shared types and constants
// Opcodes, register indexes, field widths and the pipeline stage records
// of the pointer motion accelerator.
// ----------------------------------------------------------------------------
package pma_pkg;

  localparam int DELTA_W  = 16;
  localparam int MASK_W   = 32;
  localparam int GAIN_W   = 12;
  localparam int THRESH_W = 8;
  localparam int ACC_W    = 32;
  localparam int MOTION_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [GAIN_W-1:0]   SPEED_GAIN_RST     = 12'h299;
  localparam logic [THRESH_W-1:0] FAST_THRESHOLD_RST = 8'h10;
  localparam logic [GAIN_W:0]     UNIT_GAIN          = 13'd256;

  typedef enum logic [1:0] {
    OP_START        = 2'd0,
    OP_MOTION       = 2'd1,
    OP_READ_MOTION  = 2'd2,
    OP_READ_BUTTONS = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_GAIN     = 1'd0,
    CFG_FAST_THRESHOLD = 1'd1
  } cfg_index_t;

  typedef struct packed {
    opcode_t                    op;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
    logic signed [DELTA_W-1:0]  dz;
    logic        [MASK_W-1:0]   mask;
  } item_t;

  typedef struct packed {
    item_t item;
    logic  fast;
  } classed_t;

endpackage

/* rtl/pma_classify.sv */
// ----------------------------------------------------------------------------
// pma_classify: input register and speed classification
// Holds the accepted item and decides whether its x/y magnitude is above
// the fast threshold.
// ----------------------------------------------------------------------------
module pma_classify
  import pma_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  item_t               in_item,
  input  logic [THRESH_W-1:0] fast_threshold,
  output logic                s1_valid,
  input  logic                s2_ready,
  output classed_t            s1_out
);

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;

  logic signed [2*DELTA_W-1:0]   sq_x, sq_y;
  logic        [2*DELTA_W:0]     mag;
  logic        [2*THRESH_W-1:0]  lim;
  logic                          in_xfer;

  assign in_ready = !s1_valid_r || s2_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
  end

  // squares are never negative, so their unsigned sum is exact
  always_comb begin
    sq_x = s1_item_r.dx * s1_item_r.dx;
    sq_y = s1_item_r.dy * s1_item_r.dy;
    mag  = {1'b0, $unsigned(sq_x)} + {1'b0, $unsigned(sq_y)};
    lim  = fast_threshold * fast_threshold;
  end

  assign s1_valid    = s1_valid_r;
  assign s1_out.item = s1_item_r;
  assign s1_out.fast = mag > {{(2*DELTA_W+1-2*THRESH_W){1'b0}}, lim};

endmodule

/* rtl/pma_accum.sv */
// ----------------------------------------------------------------------------
// pma_accum: gain, saturating accumulators and result register
// Scales the deltas, updates the motion and button state in item order and
// holds the read result until it is taken.
// ----------------------------------------------------------------------------
module pma_accum
  import pma_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  output logic                        s2_ready,
  input  classed_t                    s1_in,
  input  logic [GAIN_W-1:0]           speed_gain,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [MOTION_W-1:0]  out_motion_x,
  output logic signed [MOTION_W-1:0]  out_motion_y,
  output logic signed [MOTION_W-1:0]  out_motion_z,
  output logic        [MASK_W-1:0]    out_buttons_held
);

  localparam int PROD_W = DELTA_W + GAIN_W + 2;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] add
  );
    logic signed [ACC_W:0] sum;
    sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){add[PROD_W-1]}}, add};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = sum[ACC_W-1:0];
    end
  endfunction

  // divide by 256 truncating toward zero: bias negatives before the shift
  function automatic logic signed [MOTION_W-1:0] scale_out(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] biased;
    biased = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
    scale_out = biased[ACC_W-1:ACC_W-MOTION_W];
  endfunction

  logic     s2_valid_r, s2_valid_nxt;
  classed_t s2_r;

  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r, acc_z_r;
  logic signed [ACC_W-1:0]  acc_x_nxt, acc_y_nxt, acc_z_nxt;
  logic        [MASK_W-1:0] union_r, union_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [MOTION_W-1:0] mx_r, my_r, mz_r, mx_nxt, my_nxt, mz_nxt;
  logic        [MASK_W-1:0]   held_r, held_nxt;

  logic                       has_result, s2_fire, result_fire;
  logic signed [GAIN_W+1:0]   gain;
  logic signed [PROD_W-1:0]   px, py, pz;

  assign has_result  = (s2_r.item.op == OP_READ_MOTION) ||
                       (s2_r.item.op == OP_READ_BUTTONS);
  assign s2_fire     = s2_valid_r && (!has_result || !out_valid_r || out_ready);
  assign result_fire = s2_fire && has_result;
  assign s2_ready    = !s2_valid_r || s2_fire;

  always_comb begin
    if (s1_valid && s2_ready) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_fire) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
  end

  always_comb begin
    gain = s2_r.fast ? {2'b00, speed_gain} : {1'b0, UNIT_GAIN};
    px   = s2_r.item.dx * gain;
    py   = s2_r.item.dy * gain;
    pz   = s2_r.item.dz * gain;
  end

  always_comb begin
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    acc_z_nxt = acc_z_r;
    union_nxt = union_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    mz_nxt    = mz_r;
    held_nxt  = held_r;
    if (s2_fire) begin
      unique case (s2_r.item.op)
        OP_START: begin
          union_nxt = '0;
        end
        OP_MOTION: begin
          acc_x_nxt = sat_add(acc_x_r, px);
          acc_y_nxt = sat_add(acc_y_r, py);
          acc_z_nxt = sat_add(acc_z_r, pz);
          union_nxt = union_r | s2_r.item.mask;
        end
        OP_READ_MOTION: begin
          mx_nxt    = scale_out(acc_x_r);
          my_nxt    = scale_out(acc_y_r);
          mz_nxt    = scale_out(acc_z_r);
          held_nxt  = union_r;
          acc_x_nxt = '0;
          acc_y_nxt = '0;
          acc_z_nxt = '0;
        end
        OP_READ_BUTTONS: begin
          mx_nxt   = '0;
          my_nxt   = '0;
          mz_nxt   = '0;
          held_nxt = union_r;
        end
        default: begin
          union_nxt = union_r;
        end
      endcase
    end
  end

  always_comb begin
    if (result_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_z_r     <= '0;
      union_r     <= '0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      acc_z_r     <= acc_z_nxt;
      union_r     <= union_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_r <= s1_in;
    end
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    mz_r   <= mz_nxt;
    held_r <= held_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_motion_x     = mx_r;
  assign out_motion_y     = my_r;
  assign out_motion_z     = mz_r;
  assign out_buttons_held = held_r;

endmodule

/* rtl/pointer_motion_accelerator.sv */
// ----------------------------------------------------------------------------
// pointer_motion_accelerator: threshold pointer acceleration
// Accelerates and accumulates motion reports; returns scaled motion and the
// button union on reads. Holds the two configuration registers.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle when the result side keeps up.
// Path: a read result goes through the input register and magnitude compare,
// then the stage-2 register, gain multiply and accumulate, into the result
// register.
// The magnitude multiplies and the gain multiplies sit in separate stages.
// Reset: accumulators, button union and valid flags clear; gain 665, threshold 16.
module pointer_motion_accelerator
  import pma_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic        [1:0]           in_opcode,
  input  logic signed [DELTA_W-1:0]   in_delta_x,
  input  logic signed [DELTA_W-1:0]   in_delta_y,
  input  logic signed [DELTA_W-1:0]   in_delta_z,
  input  logic        [MASK_W-1:0]    in_button_mask,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [MOTION_W-1:0]  out_motion_x,
  output logic signed [MOTION_W-1:0]  out_motion_y,
  output logic signed [MOTION_W-1:0]  out_motion_z,
  output logic        [MASK_W-1:0]    out_buttons_held,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  logic [GAIN_W-1:0]   speed_gain_r, speed_gain_nxt;
  logic [THRESH_W-1:0] fast_threshold_r, fast_threshold_nxt;

  item_t    in_item;
  classed_t s1_out;
  logic     s1_valid, s2_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    speed_gain_nxt     = speed_gain_r;
    fast_threshold_nxt = fast_threshold_r;
    if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SPEED_GAIN:     speed_gain_nxt     = cfg_data[GAIN_W-1:0];
        CFG_FAST_THRESHOLD: fast_threshold_nxt = cfg_data[THRESH_W-1:0];
        default:            speed_gain_nxt     = speed_gain_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_gain_r     <= SPEED_GAIN_RST;
      fast_threshold_r <= FAST_THRESHOLD_RST;
    end else begin
      speed_gain_r     <= speed_gain_nxt;
      fast_threshold_r <= fast_threshold_nxt;
    end
  end

  assign in_item.op   = opcode_t'(in_opcode);
  assign in_item.dx   = in_delta_x;
  assign in_item.dy   = in_delta_y;
  assign in_item.dz   = in_delta_z;
  assign in_item.mask = in_button_mask;

  pma_classify u_classify (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .fast_threshold (fast_threshold_r),
    .s1_valid       (s1_valid),
    .s2_ready       (s2_ready),
    .s1_out         (s1_out)
  );

  pma_accum u_accum (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .s2_ready         (s2_ready),
    .s1_in            (s1_out),
    .speed_gain       (speed_gain_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_motion_x     (out_motion_x),
    .out_motion_y     (out_motion_y),
    .out_motion_z     (out_motion_z),
    .out_buttons_held (out_buttons_held)
  );

endmodule

/* verif/pointer_motion_accelerator_checker.sv */
// ----------------------------------------------------------------------------
// pointer_motion_accelerator_checker: motion and button readout checker
// Watches the input, configuration and result transfers of the pointer
// motion accelerator, keeps its own copy of the accumulators, button union
// and registers, and compares every result against the oldest predicted one.
// ----------------------------------------------------------------------------
module pointer_motion_accelerator_checker
  import pma_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic        [1:0]            in_opcode,
  input  logic signed [DELTA_W-1:0]    in_delta_x,
  input  logic signed [DELTA_W-1:0]    in_delta_y,
  input  logic signed [DELTA_W-1:0]    in_delta_z,
  input  logic        [MASK_W-1:0]     in_button_mask,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [MOTION_W-1:0]   out_motion_x,
  input  logic signed [MOTION_W-1:0]   out_motion_y,
  input  logic signed [MOTION_W-1:0]   out_motion_z,
  input  logic        [MASK_W-1:0]     out_buttons_held,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);

  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic [MOTION_W-1:0] motion_x;
    logic [MOTION_W-1:0] motion_y;
    logic [MOTION_W-1:0] motion_z;
    logic [MASK_W-1:0]   buttons_held;
  } readout_t;

  readout_t readout_q[$];

  logic        [GAIN_W-1:0]   gain_reg;
  logic        [THRESH_W-1:0] thresh_reg;
  logic signed [ACC_W-1:0]    acc_x;
  logic signed [ACC_W-1:0]    acc_y;
  logic signed [ACC_W-1:0]    acc_z;
  logic        [MASK_W-1:0]   held_union;

  function automatic logic signed [ACC_W-1:0] saturate_add(
    input logic signed [ACC_W-1:0] acc,
    input longint                  addend
  );
    longint sum;
    sum = longint'(acc) + addend;
    if (sum > ACC_HI) sum = ACC_HI;
    else if (sum < ACC_LO) sum = ACC_LO;
    return sum[ACC_W-1:0];
  endfunction

  // Divide by 256 truncating toward zero, keep the low 24 bits.
  function automatic logic [MOTION_W-1:0] scale_motion(input logic signed [ACC_W-1:0] acc);
    longint quot;
    quot = longint'(acc) / 256;
    return quot[MOTION_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    readout_t got;
    readout_t want;
    longint   dx;
    longint   dy;
    longint   dz;
    longint   mag;
    longint   lim;
    longint   gain;
    if (!rst_n) begin
      gain_reg   = SPEED_GAIN_RST;
      thresh_reg = FAST_THRESHOLD_RST;
      acc_x      = '0;
      acc_y      = '0;
      acc_z      = '0;
      held_union = '0;
      readout_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{motion_x: out_motion_x, motion_y: out_motion_y,
                motion_z: out_motion_z, buttons_held: out_buttons_held};
        if (readout_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: result with nothing pending: x=%0d y=%0d z=%0d buttons=%08h",
                     $signed(got.motion_x), $signed(got.motion_y),
                     $signed(got.motion_z), got.buttons_held);
        end else begin
          want = readout_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: readout mismatch: want x=%0d y=%0d z=%0d buttons=%08h, got x=%0d y=%0d z=%0d buttons=%08h",
                       $signed(want.motion_x), $signed(want.motion_y),
                       $signed(want.motion_z), want.buttons_held,
                       $signed(got.motion_x), $signed(got.motion_y),
                       $signed(got.motion_z), got.buttons_held);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_SPEED_GAIN:     gain_reg   = cfg_data[GAIN_W-1:0];
          CFG_FAST_THRESHOLD: thresh_reg = cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        case (opcode_t'(in_opcode))
          OP_START: held_union = '0;
          OP_MOTION: begin
            dx   = in_delta_x;
            dy   = in_delta_y;
            dz   = in_delta_z;
            mag  = dx * dx + dy * dy;
            lim  = longint'(thresh_reg) * longint'(thresh_reg);
            gain = (mag > lim) ? longint'(gain_reg) : longint'(UNIT_GAIN);
            acc_x = saturate_add(acc_x, dx * gain);
            acc_y = saturate_add(acc_y, dy * gain);
            acc_z = saturate_add(acc_z, dz * gain);
            held_union = held_union | in_button_mask;
          end
          OP_READ_MOTION: begin
            readout_q.push_back('{motion_x: scale_motion(acc_x), motion_y: scale_motion(acc_y),
                                  motion_z: scale_motion(acc_z), buttons_held: held_union});
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
          end
          OP_READ_BUTTONS: begin
            readout_q.push_back('{motion_x: '0, motion_y: '0, motion_z: '0,
                                  buttons_held: held_union});
          end
          default: ;
        endcase
      end
    end
    pending = readout_q.size();
  end

endmodule

/* verif/pointer_motion_accelerator_tb.sv */
// ----------------------------------------------------------------------------
// pointer_motion_accelerator_tb: top-level testbench
// Drives directed and random motion report streams through the accelerator
// under several gain and threshold settings, with random gaps on the input
// and random back-pressure on the result side. The checker does the scoring.
// ----------------------------------------------------------------------------
module pointer_motion_accelerator_tb;
  import pma_pkg::*;

  localparam int TIMEOUT     = 20_000_000;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 7;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic        [1:0]            in_opcode      = '0;
  logic signed [DELTA_W-1:0]    in_delta_x     = '0;
  logic signed [DELTA_W-1:0]    in_delta_y     = '0;
  logic signed [DELTA_W-1:0]    in_delta_z     = '0;
  logic        [MASK_W-1:0]     in_button_mask = '0;
  logic                         out_ready      = 1'b0;
  logic                         cfg_valid      = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic        [CFG_DATA_W-1:0] cfg_data       = '0;

  logic                         in_ready;
  logic                         out_valid;
  logic signed [MOTION_W-1:0]   out_motion_x;
  logic signed [MOTION_W-1:0]   out_motion_y;
  logic signed [MOTION_W-1:0]   out_motion_z;
  logic        [MASK_W-1:0]     out_buttons_held;
  logic                         cfg_ready;

  int fail_count;
  int pending;
  int cur_thr    = 16;
  bit no_idle    = 1'b0;
  int ready_mode = 0;
  int ready_hold = 0;

  int gain_list[NUM_PHASES] = '{4095, 0,   256, 4095, 1, 2048, 665};
  int thr_list[NUM_PHASES]  = '{0,    255, 16,  255,  1, 40,   16};

  always #10 clk = ~clk;

  pointer_motion_accelerator dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_opcode, .in_delta_x, .in_delta_y, .in_delta_z, .in_button_mask,
    .out_valid, .out_ready, .out_motion_x, .out_motion_y, .out_motion_z, .out_buttons_held,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pointer_motion_accelerator_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_opcode, .in_delta_x, .in_delta_y, .in_delta_z, .in_button_mask,
    .out_valid, .out_ready, .out_motion_x, .out_motion_y, .out_motion_z, .out_buttons_held,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // Result-side back-pressure: switch at random between full speed, light,
  // heavy and long stalls.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(20, 200);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DELTA_W-1:0] rand_delta(input int style, input bit neg);
    int mag;
    case (style)
      0: return DELTA_W'(int'($urandom_range(0, 2 * cur_thr + 4)) - (cur_thr + 2));
      1: return DELTA_W'($urandom());
      2: begin
        case ($urandom_range(0, 5))
          0:       return 16'sh8000;
          1:       return 16'sh8001;
          2:       return 16'sh7fff;
          3:       return -16'sd1;
          4:       return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: begin
        // large and of one sign, to drive the accumulators into saturation
        mag = $urandom_range(24576, 32767);
        return DELTA_W'(neg ? -mag : mag);
      end
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    if ($urandom_range(0, 1) != 0) return 32'h1 << $urandom_range(0, 31);
    return $urandom();
  endfunction

  task automatic send_item(
    input opcode_t                   op,
    input logic signed [DELTA_W-1:0] dx,
    input logic signed [DELTA_W-1:0] dy,
    input logic signed [DELTA_W-1:0] dz,
    input logic        [MASK_W-1:0]  mask
  );
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_delta_x     <= dx;
    in_delta_y     <= dy;
    in_delta_z     <= dz;
    in_button_mask <= mask;
    do @(posedge clk); while (!in_ready);
  endtask

  // Opcodes that ignore the payload still get random junk on it.
  task automatic send_bare(input opcode_t op);
    send_item(op, DELTA_W'($urandom()), DELTA_W'($urandom()), DELTA_W'($urandom()), $urandom());
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_accel(input int gain, input int thr);
    write_reg(CFG_SPEED_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_FAST_THRESHOLD, CFG_DATA_W'(thr));
    cur_thr = thr;
  endtask

  // Drop valid, let every pending readout arrive, then let the pipeline drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int budget);
    int  sent;
    int  len;
    int  style;
    int  r;
    bit  neg;
    sent = 0;
    while (sent < budget) begin
      no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(opcode_t'($urandom_range(0, 3)), rand_delta(1, 1'b0), rand_delta(1, 1'b0),
                    rand_delta(1, 1'b0), $urandom());
          sent++;
        end
      end else begin
        if ($urandom_range(0, 1) != 0) begin
          send_bare(OP_START);
          sent++;
        end
        style = $urandom_range(0, 3);
        neg   = $urandom_range(0, 1);
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
        repeat (len) begin
          send_item(OP_MOTION, rand_delta(style, neg), rand_delta(style, neg),
                    rand_delta(style, neg), rand_mask());
          sent++;
        end
        // r == 1 leaves the round unread so motion piles up across sequences
        if (r != 1) begin
          case ($urandom_range(0, 2))
            0: send_bare(OP_READ_MOTION);
            1: send_bare(OP_READ_BUTTONS);
            default: begin
              send_bare(OP_READ_BUTTONS);
              send_bare(OP_READ_MOTION);
            end
          endcase
          sent++;
        end
      end
    end
  endtask

  initial begin
    #TIMEOUT;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gain 665, threshold 16
    send_bare(OP_READ_MOTION);
    send_bare(OP_READ_BUTTONS);
    send_item(OP_MOTION, 16'sd16, 16'sd0, -16'sd1, 32'h0000_0001);   // on the threshold: slow
    send_item(OP_MOTION, 16'sd0, -16'sd16, 16'sd1, 32'h8000_0000);
    send_item(OP_MOTION, 16'sd16, 16'sd1, 16'sd0, 32'h0000_0000);    // just over: fast
    send_bare(OP_READ_BUTTONS);
    send_bare(OP_READ_MOTION);
    send_item(OP_MOTION, -16'sd17, 16'sd0, 16'sd17, 32'h0000_ffff);  // fractional, negative
    send_bare(OP_READ_MOTION);
    send_item(OP_MOTION, 16'sh8000, 16'sh8000, 16'sh8000, 32'hffff_ffff);
    send_item(OP_MOTION, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'h0000_0000);
    send_bare(OP_START);
    send_bare(OP_READ_BUTTONS);
    send_bare(OP_READ_MOTION);

    // zero threshold: only zero x and y stays slow
    wait_idle();
    set_accel(gain_list[0], thr_list[0]);
    send_item(OP_MOTION, 16'sd0, 16'sd0, 16'sd5, 32'h5555_5555);
    send_item(OP_MOTION, 16'sd0, 16'sd1, 16'sd0, 32'haaaa_aaaa);
    send_item(OP_MOTION, -16'sd1, 16'sd0, -16'sd3, 32'h0000_0000);
    send_bare(OP_READ_MOTION);
    send_bare(OP_START);
    send_bare(OP_READ_BUTTONS);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p == 5) set_accel($urandom_range(0, 4095), $urandom_range(0, 255));
      else set_accel(gain_list[p], thr_list[p]);
      random_phase(PHASE_ITEMS);
    end

    no_idle = 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
